// File: sv/scfp_pkg.sv
package scfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int FLEN_W  = 6;
  localparam int FIDX_W  = 5;

  localparam logic [BYTE_W-1:0] HDR_START = 8'h24;
  localparam logic [BYTE_W-1:0] HDR_M     = 8'h4D;
  localparam logic [BYTE_W-1:0] HDR_DIR   = 8'h3C;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_M,
    ST_DIR,
    ST_LEN,
    ST_CMD,
    ST_DATA,
    ST_LOAD,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic hold_len;
    logic hold_cmd;
    logic store_byte;
    logic end_frame;
    logic load_empty;
    logic load_out;
    logic advance;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_m;
    logic is_dir;
    logic too_big;
    logic count_done;
    logic xor_match;
    logic len_zero;
    logic rd_last;
  } dp_status_t;

endpackage

// File: sv/scfp_ctrl.sv
module scfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_stall,
  input  scfp_pkg::dp_status_t sts,
  output scfp_pkg::ctl_cmd_t   cmd,
  output logic                 in_stall,
  output logic                 out_valid
);

  scfp_pkg::state_t state_r;
  scfp_pkg::state_t state_nxt;
  logic             acc;

  assign in_stall  = (state_r == scfp_pkg::ST_LOAD) || (state_r == scfp_pkg::ST_SHOW);
  assign out_valid = (state_r == scfp_pkg::ST_SHOW);
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scfp_pkg::ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scfp_pkg::ST_HUNT: begin
        if (acc) begin
          state_nxt = sts.is_start ? scfp_pkg::ST_M : scfp_pkg::ST_HUNT;
        end
      end
      scfp_pkg::ST_M: begin
        if (acc) begin
          state_nxt = sts.is_m ? scfp_pkg::ST_DIR : scfp_pkg::ST_HUNT;
        end
      end
      scfp_pkg::ST_DIR: begin
        if (acc) begin
          state_nxt = sts.is_dir ? scfp_pkg::ST_LEN : scfp_pkg::ST_HUNT;
        end
      end
      scfp_pkg::ST_LEN: begin
        if (acc) begin
          state_nxt = sts.too_big ? scfp_pkg::ST_HUNT : scfp_pkg::ST_CMD;
        end
      end
      scfp_pkg::ST_CMD: begin
        if (acc) begin
          state_nxt = scfp_pkg::ST_DATA;
        end
      end
      scfp_pkg::ST_DATA: begin
        if (acc && sts.count_done) begin
          if (!sts.xor_match) begin
            state_nxt = scfp_pkg::ST_HUNT;
          end else if (sts.len_zero) begin
            state_nxt = scfp_pkg::ST_SHOW;
          end else begin
            state_nxt = scfp_pkg::ST_LOAD;
          end
        end
      end
      scfp_pkg::ST_LOAD: begin
        state_nxt = scfp_pkg::ST_SHOW;
      end
      scfp_pkg::ST_SHOW: begin
        if (!out_stall) begin
          state_nxt = sts.rd_last ? scfp_pkg::ST_HUNT : scfp_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = scfp_pkg::ST_HUNT;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.hold_len   = (state_r == scfp_pkg::ST_LEN) && acc && !sts.too_big;
    cmd.hold_cmd   = (state_r == scfp_pkg::ST_CMD) && acc;
    cmd.store_byte = (state_r == scfp_pkg::ST_DATA) && acc && !sts.count_done;
    cmd.end_frame  = (state_r == scfp_pkg::ST_DATA) && acc && sts.count_done;
    cmd.load_empty = cmd.end_frame && sts.xor_match && sts.len_zero;
    cmd.load_out   = (state_r == scfp_pkg::ST_LOAD);
    cmd.advance    = (state_r == scfp_pkg::ST_SHOW) && !out_stall;
  end

endmodule

// File: sv/scfp_dp.sv
module scfp_dp #(
  parameter int MAX_PAYLOAD = scfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [scfp_pkg::BYTE_W-1:0]   in_rx_byte,
  input  scfp_pkg::ctl_cmd_t            cmd,
  output scfp_pkg::dp_status_t          sts,
  output logic [scfp_pkg::BYTE_W-1:0]   out_frame_cmd,
  output logic [scfp_pkg::FLEN_W-1:0]   out_frame_len,
  output logic [scfp_pkg::BYTE_W-1:0]   out_payload_byte,
  output logic [scfp_pkg::FIDX_W-1:0]   out_byte_index,
  output logic                          out_has_data,
  output logic                          out_last
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [scfp_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];

  logic [CNT_W-1:0]            held_len_r;
  logic [scfp_pkg::BYTE_W-1:0] held_cmd_r;
  logic [CNT_W-1:0]            count_r;
  logic [scfp_pkg::BYTE_W-1:0] xor_r;
  logic [CNT_W-1:0]            rd_idx_r;
  logic [CNT_W-1:0]            rd_idx_inc;

  logic [scfp_pkg::BYTE_W-1:0] out_payload_r;
  logic [scfp_pkg::FIDX_W-1:0] out_index_r;
  logic                        out_has_r;
  logic                        out_last_r;

  assign rd_idx_inc = CNT_W'(rd_idx_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_len_r <= '0;
      held_cmd_r <= '0;
      count_r    <= '0;
      xor_r      <= '0;
      rd_idx_r   <= '0;
    end else begin
      if (cmd.hold_len) begin
        held_len_r <= CNT_W'(in_rx_byte);
      end
      if (cmd.hold_cmd) begin
        held_cmd_r <= in_rx_byte;
      end
      if (cmd.hold_len || cmd.hold_cmd || cmd.store_byte) begin
        xor_r <= xor_r ^ in_rx_byte;
      end else if (cmd.end_frame) begin
        xor_r <= '0;
      end
      if (cmd.store_byte) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (cmd.end_frame) begin
        count_r <= '0;
      end
      if (cmd.end_frame) begin
        rd_idx_r <= '0;
      end else if (cmd.advance) begin
        rd_idx_r <= rd_idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      mem[count_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_payload_r <= mem[rd_idx_r[IDX_W-1:0]];
      out_index_r   <= scfp_pkg::FIDX_W'(rd_idx_r);
      out_has_r     <= 1'b1;
      out_last_r    <= (rd_idx_inc == held_len_r);
    end else if (cmd.load_empty) begin
      out_payload_r <= '0;
      out_index_r   <= '0;
      out_has_r     <= 1'b0;
      out_last_r    <= 1'b1;
    end
  end

  always_comb begin
    sts            = '0;
    sts.is_start   = (in_rx_byte == scfp_pkg::HDR_START);
    sts.is_m       = (in_rx_byte == scfp_pkg::HDR_M);
    sts.is_dir     = (in_rx_byte == scfp_pkg::HDR_DIR);
    sts.too_big    = (in_rx_byte > scfp_pkg::BYTE_W'(MAX_PAYLOAD));
    sts.count_done = (count_r == held_len_r);
    sts.xor_match  = (xor_r == in_rx_byte);
    sts.len_zero   = (held_len_r == '0);
    sts.rd_last    = out_last_r;
  end

  assign out_frame_cmd    = held_cmd_r;
  assign out_frame_len    = scfp_pkg::FLEN_W'(held_len_r);
  assign out_payload_byte = out_payload_r;
  assign out_byte_index   = out_index_r;
  assign out_has_data     = out_has_r;
  assign out_last         = out_last_r;

endmodule

// File: sv/serial_command_frame_parser_core.sv
// Parses '$' 'M' '<' length command payload checksum frames, one received
// byte per input beat. While a frame is coming in, input never stalls.
// When the checksum byte matches, input stalls and the stored payload is
// replayed as one result beat per payload byte, each passing through a
// payload buffer read, then the held output beat, which waits out any
// output stall; a zero-length frame gives one result beat in the cycle
// after its checksum. Frames with a bad header byte, a length above
// MAX_PAYLOAD or a checksum mismatch produce no output.
module serial_command_frame_parser_core #(
  parameter int MAX_PAYLOAD = scfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [scfp_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scfp_pkg::BYTE_W-1:0]   out_frame_cmd,
  output logic [scfp_pkg::FLEN_W-1:0]   out_frame_len,
  output logic [scfp_pkg::BYTE_W-1:0]   out_payload_byte,
  output logic [scfp_pkg::FIDX_W-1:0]   out_byte_index,
  output logic                          out_has_data,
  output logic                          out_last
);

  scfp_pkg::ctl_cmd_t   cmd;
  scfp_pkg::dp_status_t sts;

  scfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  scfp_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_frame_cmd    (out_frame_cmd),
    .out_frame_len    (out_frame_len),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_has_data     (out_has_data),
    .out_last         (out_last)
  );

endmodule

// File: tb/sv/frame_result_checker.sv
`timescale 1ns / 100ps

module frame_result_checker #(
  parameter int MAX_PAYLOAD = scfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [scfp_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [scfp_pkg::BYTE_W-1:0] out_frame_cmd,
  input  logic [scfp_pkg::FLEN_W-1:0] out_frame_len,
  input  logic [scfp_pkg::BYTE_W-1:0] out_payload_byte,
  input  logic [scfp_pkg::FIDX_W-1:0] out_byte_index,
  input  logic                        out_has_data,
  input  logic                        out_last,
  output int unsigned                 mismatches,
  output int unsigned                 beats_due
);

  typedef struct packed {
    logic [scfp_pkg::BYTE_W-1:0] cmd;
    logic [scfp_pkg::FLEN_W-1:0] len;
    logic [scfp_pkg::BYTE_W-1:0] data;
    logic [scfp_pkg::FIDX_W-1:0] idx;
    logic                        has_data;
    logic                        last;
  } frame_beat_t;

  frame_beat_t                 frame_beats_due[$];
  scfp_pkg::state_t            phase = scfp_pkg::ST_HUNT;
  logic [scfp_pkg::FLEN_W-1:0] held_len = '0;
  logic [scfp_pkg::BYTE_W-1:0] held_cmd = '0;
  logic [scfp_pkg::FLEN_W-1:0] bytes_taken = '0;
  logic [scfp_pkg::BYTE_W-1:0] xor_sum = '0;
  logic [scfp_pkg::BYTE_W-1:0] payload_buf [MAX_PAYLOAD];
  int unsigned                 fail_count = 0;

  task automatic parse_rx_byte(input logic [scfp_pkg::BYTE_W-1:0] c);
    int i;
    case (phase)
      scfp_pkg::ST_M: phase = (c == scfp_pkg::HDR_M) ? scfp_pkg::ST_DIR : scfp_pkg::ST_HUNT;
      scfp_pkg::ST_DIR: phase = (c == scfp_pkg::HDR_DIR) ? scfp_pkg::ST_LEN : scfp_pkg::ST_HUNT;
      scfp_pkg::ST_LEN: begin
        if (c > MAX_PAYLOAD) begin
          phase = scfp_pkg::ST_HUNT;
        end else begin
          held_len = c[scfp_pkg::FLEN_W-1:0];
          xor_sum = xor_sum ^ c;
          phase = scfp_pkg::ST_CMD;
        end
      end
      scfp_pkg::ST_CMD: begin
        held_cmd = c;
        xor_sum = xor_sum ^ c;
        phase = scfp_pkg::ST_DATA;
      end
      scfp_pkg::ST_DATA: begin
        if (bytes_taken < held_len) begin
          payload_buf[bytes_taken] = c;
          bytes_taken = bytes_taken + 1'b1;
          xor_sum = xor_sum ^ c;
        end else begin
          if (xor_sum == c) begin
            if (held_len == 0) begin
              frame_beats_due.push_back('{held_cmd, held_len, '0, '0, 1'b0, 1'b1});
            end else begin
              for (i = 0; i < held_len; i++) begin
                frame_beats_due.push_back('{held_cmd, held_len, payload_buf[i],
                                            i[scfp_pkg::FIDX_W-1:0],
                                            1'b1, (i == held_len - 1)});
              end
            end
          end
          bytes_taken = '0;
          xor_sum = '0;
          phase = scfp_pkg::ST_HUNT;
        end
      end
      default: phase = (c == scfp_pkg::HDR_START) ? scfp_pkg::ST_M : scfp_pkg::ST_HUNT;
    endcase
  endtask

  task automatic note_mismatch(input string what, input frame_beat_t e, input frame_beat_t a);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: exp cmd=%h len=%0d data=%h idx=%0d has=%b last=%b", $realtime, what,
               e.cmd, e.len, e.data, e.idx, e.has_data, e.last);
      $display("%0t %s: got cmd=%h len=%0d data=%h idx=%0d has=%b last=%b", $realtime, what,
               a.cmd, a.len, a.data, a.idx, a.has_data, a.last);
    end
  endtask

  always @(posedge clk) begin
    frame_beat_t seen;
    frame_beat_t want;
    if (!rst_n) begin
      phase = scfp_pkg::ST_HUNT;
      held_len = '0;
      held_cmd = '0;
      bytes_taken = '0;
      xor_sum = '0;
      frame_beats_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        parse_rx_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        seen = '{out_frame_cmd, out_frame_len, out_payload_byte, out_byte_index,
                 out_has_data, out_last};
        if (frame_beats_due.size() == 0) begin
          note_mismatch("unexpected beat", '0, seen);
        end else begin
          want = frame_beats_due.pop_front();
          if (seen !== want) begin
            note_mismatch("beat mismatch", want, seen);
          end
        end
      end
    end
    beats_due <= $unsigned(frame_beats_due.size());
    mismatches <= fail_count;
  end

endmodule

// File: tb/sv/serial_command_frame_parser_core_test.sv
`timescale 1ns / 100ps

module serial_command_frame_parser_core_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int RANDOM_BYTES   = 160;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [scfp_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [scfp_pkg::BYTE_W-1:0] out_frame_cmd;
  logic [scfp_pkg::FLEN_W-1:0] out_frame_len;
  logic [scfp_pkg::BYTE_W-1:0] out_payload_byte;
  logic [scfp_pkg::FIDX_W-1:0] out_byte_index;
  logic                        out_has_data;
  logic                        out_last;
  int unsigned                 mismatches;
  int unsigned                 beats_due;
  int unsigned                 idle_cycles = 0;
  int unsigned                 frame_bytes = 0;
  bit                          quiet = 1'b0;
  bit                          hold_req = 1'b0;

  always #6 clk = ~clk;

  serial_command_frame_parser_core dut (.*);

  frame_result_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic put_byte(input logic [scfp_pkg::BYTE_W-1:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input int unsigned len, input logic [scfp_pkg::BYTE_W-1:0] cmd,
                            input logic [scfp_pkg::BYTE_W-1:0] sum_flip);
    logic [scfp_pkg::BYTE_W-1:0] sum;
    logic [scfp_pkg::BYTE_W-1:0] b;
    int i;
    put_byte(scfp_pkg::HDR_START);
    put_byte(scfp_pkg::HDR_M);
    put_byte(scfp_pkg::HDR_DIR);
    put_byte(len[scfp_pkg::BYTE_W-1:0]);
    if (len > scfp_pkg::MAX_PAYLOAD_DEF) begin
      frame_bytes += 4;
      return;
    end
    sum = len[scfp_pkg::BYTE_W-1:0] ^ cmd;
    put_byte(cmd);
    for (i = 0; i < len; i++) begin
      b = scfp_pkg::BYTE_W'($urandom_range(0, 255));
      sum = sum ^ b;
      put_byte(b);
    end
    put_byte(sum ^ sum_flip);
    frame_bytes += len + 6;
  endtask

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
  endfunction

  initial begin
    int unsigned                 nframe;
    int unsigned                 stub;
    logic [scfp_pkg::BYTE_W-1:0] b;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(0, 8'hFF, 8'h00);
    put_byte(scfp_pkg::HDR_START);
    put_byte(scfp_pkg::HDR_START);
    put_byte(scfp_pkg::HDR_M);
    put_byte(scfp_pkg::HDR_DIR);
    frame_bytes += 4;
    send_frame(33, 8'h00, 8'h00);
    send_frame(1, 8'h00, 8'h00);
    send_frame(2, 8'hA5, 8'h80);

    nframe = 0;
    while (frame_bytes < RANDOM_BYTES) begin
      if (frame_bytes > RANDOM_BYTES - 40) quiet = 1'b1;
      if (nframe == 3) begin
        hold_req = 1'b1;
        send_frame(32, scfp_pkg::BYTE_W'($urandom_range(0, 255)), 8'h00);
      end else begin
        case ($urandom_range(0, 9))
          0: put_byte(scfp_pkg::BYTE_W'($urandom_range(0, 255)));
          1: begin
            stub = $urandom_range(1, 2);
            put_byte(scfp_pkg::HDR_START);
            if (stub == 2) put_byte(scfp_pkg::HDR_M);
            b = scfp_pkg::BYTE_W'($urandom_range(0, 255));
            if (b == ((stub == 2) ? scfp_pkg::HDR_DIR : scfp_pkg::HDR_M)) begin
              b = scfp_pkg::HDR_START;
            end
            put_byte(b);
            frame_bytes += stub + 1;
          end
          2: send_frame($urandom_range(33, 255), scfp_pkg::BYTE_W'($urandom_range(0, 255)),
                        8'h00);
          3: send_frame(pick_len(), scfp_pkg::BYTE_W'($urandom_range(0, 255)),
                        scfp_pkg::BYTE_W'($urandom_range(1, 255)));
          default: send_frame(pick_len(), scfp_pkg::BYTE_W'($urandom_range(0, 255)), 8'h00);
        endcase
      end
      nframe++;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (beats_due != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && beats_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
